>>> rtl/bsh_pkg.sv
// Shared types, codes and helpers for the binned-sum histogram core.
// Depends on nothing; the record store and the core take names from here by scope.
package bsh_pkg;

  // Operation codes carried in cmd.operation
  localparam logic [1:0] OP_ADD       = 2'd0;
  localparam logic [1:0] OP_SCALE_ONE = 2'd1;
  localparam logic [1:0] OP_SCALE_ALL = 2'd2;
  localparam logic [1:0] OP_READ      = 2'd3;

  // Status codes carried in result.status
  localparam logic [1:0] ST_IN_RANGE  = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_INVALID   = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE   = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] sample_x;
    logic signed [31:0] sample_q2;
    logic [6:0]         record_index;
    logic [31:0]        factor;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [6:0]         bin_number;
    logic [31:0]        entry_count;
    logic [47:0]        scaled_count;
    logic signed [47:0] sum_x;
    logic signed [47:0] sum_q2;
    logic [31:0]        scale_value;
  } result_t;

  // One histogram record as held in the store
  typedef struct packed {
    logic [31:0]        entries;
    logic [47:0]        scaled;
    logic signed [47:0] sum_x;
    logic signed [47:0] sum_q2;
    logic [31:0]        scale;
  } record_t;

  function automatic logic signed [47:0] sat_add48(input logic signed [47:0] a,
                                                   input logic signed [47:0] b);
    logic signed [48:0] s;
    s = {a[47], a} + {b[47], b};
    if (s[48] != s[47]) begin
      sat_add48 = s[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    end else begin
      sat_add48 = s[47:0];
    end
  endfunction

endpackage

>>> rtl/bsh_mul.sv
// Registered 32 x 32 unsigned multiplier shared by binning and scaling.
// Depends on nothing.
module bsh_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule

>>> rtl/bsh_record_mem.sv
// Record store: one write port, one read port with registered read data.
// Depends on bsh_pkg for the record type.
module bsh_record_mem #(
  parameter int DEPTH = 66,
  parameter int AW    = 7
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  bsh_pkg::record_t  wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output bsh_pkg::record_t  rdata
);

  bsh_pkg::record_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/binned_sum_histogram_core.sv
// Top level of the binned-sum histogram core: command handling, sequencer.
// Depends on bsh_pkg, bsh_mul and bsh_record_mem.
//
// Histogram engine over Q16.16 samples. Issue a command word by raising start
// while busy is low; exactly one result word follows on result, marked by a
// one-cycle done strobe that the receiver must take as it comes, since there
// is no way to hold it off. After reset the core sweeps its record store, one
// record a cycle, and stays busy until the sweep ends; configuration writes
// are taken at any time but belong in idle periods. Every record lives in a
// single-port-read store with registered read data, and each update is a
// read, modify and write-back of one record; scaling runs three passes
// through one shared 32 x 32 multiplier per record.
module binned_sum_histogram_core #(
  parameter int MAX_BINS      = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  bsh_pkg::cmd_t                   cmd,
  output logic                            done,
  output bsh_pkg::result_t                result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bsh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);

  localparam int REC    = MAX_BINS + 2;
  localparam int IDX_W  = $clog2(REC);
  localparam int CNT_W  = $clog2(MAX_BINS + 1);
  localparam int UF_REC = MAX_BINS;
  localparam int OF_REC = MAX_BINS + 1;
  localparam logic [31:0] ONE = 32'(1) << FRACTION_BITS;

  // sequencer states
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_BIN   = 4'd2;
  localparam logic [3:0] S_LOOK  = 4'd3;
  localparam logic [3:0] S_ADD   = 4'd4;
  localparam logic [3:0] S_FETCH = 4'd5;
  localparam logic [3:0] S_SC0   = 4'd6;
  localparam logic [3:0] S_SC1   = 4'd7;
  localparam logic [3:0] S_SC2   = 4'd8;
  localparam logic [3:0] S_SC3   = 4'd9;
  localparam logic [3:0] S_RD    = 4'd10;

  // configuration
  logic signed [31:0] range_low;
  logic [31:0]        inverse_width;
  logic [6:0]         bins_in_use;

  // control
  logic [3:0]       state;
  logic [IDX_W-1:0] rec_addr;
  logic             walk;
  logic             last;
  logic             done_next;

  // captured command payload
  logic signed [31:0] x_r;
  logic signed [31:0] q2_r;
  logic [31:0]        f_r;
  logic signed [32:0] diff_r;
  logic [63:0]        p_scale;
  logic [63:0]        p_lo;

  logic [CNT_W-1:0] eff;
  logic             accept;
  logic             idx_bad;
  logic [63:0]      bin_q;
  logic [IDX_W-1:0] look_rec;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  bsh_pkg::record_t  mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  bsh_pkg::record_t  rdata;

  bsh_pkg::record_t  add_rec;
  bsh_pkg::record_t  scl_rec;
  bsh_pkg::record_t  clr_rec;
  logic [48:0]       scaled_inc;
  logic [79:0]       scl_full;
  logic [79:0]       scl_sh;
  logic [63:0]       scale_sh;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;

  // bins in use, capped at MAX_BINS
  assign eff = (int'(bins_in_use) > MAX_BINS) ? CNT_W'(MAX_BINS) : CNT_W'(bins_in_use);

  // bad index: past the overflow record, or an in-range bin beyond those in use
  assign idx_bad = (int'(cmd.record_index) > OF_REC) ||
                   ((int'(cmd.record_index) < MAX_BINS) &&
                    (int'(cmd.record_index) >= int'(eff)));

  // bin lookup from the registered product (diff * inverse_width)
  assign bin_q = mul_p >> (2 * FRACTION_BITS);
  always_comb begin
    if (diff_r[32]) begin
      look_rec = IDX_W'(UF_REC);
    end else if (bin_q >= 64'(eff)) begin
      look_rec = IDX_W'(OF_REC);
    end else begin
      look_rec = IDX_W'(bin_q);
    end
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = diff_r[31:0];
    mul_b = f_r;
    case (state)
      S_BIN: begin
        mul_a = diff_r[31:0];
        mul_b = inverse_width;
      end
      S_SC0:   mul_a = rdata.scale;
      S_SC1:   mul_a = rdata.scaled[31:0];
      S_SC2:   mul_a = {16'b0, rdata.scaled[47:32]};
      default: mul_a = diff_r[31:0];
    endcase
  end

  bsh_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // record after adding one sample
  always_comb begin
    add_rec         = rdata;
    add_rec.entries = (&rdata.entries) ? rdata.entries : rdata.entries + 32'd1;
    scaled_inc      = {1'b0, rdata.scaled} + {17'b0, ONE};
    add_rec.scaled  = scaled_inc[48] ? {48{1'b1}} : scaled_inc[47:0];
    add_rec.sum_x   = bsh_pkg::sat_add48(rdata.sum_x, 48'(x_r));
    add_rec.sum_q2  = bsh_pkg::sat_add48(rdata.sum_q2, 48'(q2_r));
  end

  // record after scaling: scaled = (hi*f << 32) + lo*f, both shifted down
  always_comb begin
    scl_rec        = rdata;
    scl_full       = {mul_p[47:0], 32'b0} + {16'b0, p_lo};
    scl_sh         = scl_full >> FRACTION_BITS;
    scale_sh       = p_scale >> FRACTION_BITS;
    scl_rec.scaled = (|scl_sh[79:48]) ? {48{1'b1}} : scl_sh[47:0];
    scl_rec.scale  = (|scale_sh[63:32]) ? {32{1'b1}} : scale_sh[31:0];
  end

  always_comb begin
    clr_rec         = '0;
    clr_rec.scale   = ONE;
  end

  // store ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rec_addr;
    mem_wdata = clr_rec;
    mem_re    = 1'b0;
    mem_raddr = rec_addr;
    case (state)
      S_CLEAR: mem_we = 1'b1;
      S_ADD: begin
        mem_we    = 1'b1;
        mem_wdata = add_rec;
      end
      S_SC3: begin
        mem_we    = 1'b1;
        mem_wdata = scl_rec;
      end
      S_IDLE: begin
        mem_re    = accept && (cmd.operation != bsh_pkg::OP_ADD) &&
                    ((cmd.operation == bsh_pkg::OP_SCALE_ALL) || !idx_bad);
        mem_raddr = (cmd.operation == bsh_pkg::OP_SCALE_ALL) ? '0
                                                             : IDX_W'(cmd.record_index);
      end
      S_LOOK: begin
        mem_re    = 1'b1;
        mem_raddr = look_rec;
      end
      S_FETCH: mem_re = 1'b1;
      default: mem_we = 1'b0;
    endcase
  end

  bsh_record_mem #(
    .DEPTH (REC),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  function automatic bsh_pkg::result_t emit(input bsh_pkg::record_t r,
                                            input logic [IDX_W-1:0] a);
    bsh_pkg::result_t o;
    if (int'(a) == UF_REC) begin
      o.status = bsh_pkg::ST_UNDERFLOW;
    end else if (int'(a) == OF_REC) begin
      o.status = bsh_pkg::ST_OVERFLOW;
    end else begin
      o.status = bsh_pkg::ST_IN_RANGE;
    end
    o.bin_number   = 7'(a);
    o.entry_count  = r.entries;
    o.scaled_count = r.scaled;
    o.sum_x        = r.sum_x;
    o.sum_q2       = r.sum_q2;
    o.scale_value  = r.scale;
    return o;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low     <= '0;
      inverse_width <= 32'd65536;
      bins_in_use   <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bsh_pkg::CFG_RANGE_LOW:     range_low     <= cfg_data;
        bsh_pkg::CFG_INVERSE_WIDTH: inverse_width <= cfg_data;
        bsh_pkg::CFG_BINS_IN_USE:   bins_in_use   <= cfg_data[6:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // raise the strobe in the cycle after a command completes
  always_comb begin
    case (state)
      S_IDLE:      done_next = accept && idx_bad &&
                               (cmd.operation inside {bsh_pkg::OP_SCALE_ONE, bsh_pkg::OP_READ});
      S_ADD, S_RD: done_next = 1'b1;
      S_SC3:       done_next = !walk;
      default:     done_next = 1'b0;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      rec_addr <= '0;
      walk     <= 1'b0;
      last     <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= done_next;
      case (state)
        S_CLEAR: begin
          // sweep the store back to empty records with unit scale
          if (int'(rec_addr) == REC - 1) begin
            rec_addr <= '0;
            state    <= S_IDLE;
          end else begin
            rec_addr <= rec_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            walk <= (cmd.operation == bsh_pkg::OP_SCALE_ALL);
            last <= 1'b0;
            case (cmd.operation)
              bsh_pkg::OP_ADD: state <= S_BIN;
              bsh_pkg::OP_SCALE_ALL: begin
                rec_addr <= '0;
                state    <= (eff == '0) ? S_RD : S_SC0;
              end
              default: begin
                if (!idx_bad) begin
                  rec_addr <= IDX_W'(cmd.record_index);
                  state    <= (cmd.operation == bsh_pkg::OP_READ) ? S_RD : S_SC0;
                end
              end
            endcase
          end
        end
        S_BIN:  state <= S_LOOK;
        S_LOOK: begin
          rec_addr <= look_rec;
          state    <= S_ADD;
        end
        S_ADD: state <= S_IDLE;
        S_SC0: state <= S_SC1;
        S_SC1: state <= S_SC2;
        S_SC2: state <= S_SC3;
        S_SC3: begin
          if (!walk) begin
            state <= S_IDLE;
          end else if (int'(rec_addr) + 1 < int'(eff)) begin
            rec_addr <= rec_addr + 1'b1;
            state    <= S_FETCH;
          end else begin
            // walk finished: report bin zero
            rec_addr <= '0;
            last     <= 1'b1;
            state    <= S_FETCH;
          end
        end
        S_FETCH: state <= last ? S_RD : S_SC0;
        S_RD: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= cmd.sample_x;
      q2_r   <= cmd.sample_q2;
      f_r    <= cmd.factor;
      diff_r <= 33'(cmd.sample_x) - 33'(range_low);
    end
    if (state == S_SC1) begin
      p_scale <= mul_p;
    end
    if (state == S_SC2) begin
      p_lo <= mul_p;
    end
    case (state)
      S_IDLE: begin
        if (accept && idx_bad && (cmd.operation == bsh_pkg::OP_SCALE_ONE ||
                                  cmd.operation == bsh_pkg::OP_READ)) begin
          result <= '{status: bsh_pkg::ST_INVALID, bin_number: cmd.record_index,
                      default: '0};
        end
      end
      S_ADD:   result <= emit(add_rec, rec_addr);
      S_SC3:   result <= emit(scl_rec, rec_addr);
      S_RD:    result <= emit(rdata, rec_addr);
      default: ;
    endcase
  end

  // read and write never share a cycle: every update reads before it writes
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("record store read and write in the same cycle");

  a_waddr_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (int'(mem_waddr) < REC))
    else $error("record store write beyond last record");

  a_add_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.operation == bsh_pkg::OP_ADD) |-> ##4 done)
    else $error("sample add result missing four cycles after accept");

  a_busy_after_reset: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> busy)
    else $error("core not busy while sweeping store after reset");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("record store written while idle");

endmodule
